/* rtl/core/kwm_pkg.sv */
// ----------------------------------------------------------------------------
// kwm_pkg: shared types and constants of the k-way sorted merge
// Lane count, value width, command and result formats, lane bank control.
// ----------------------------------------------------------------------------
package kwm_pkg;

    // fixed geometry of the lane bank and the payload
    localparam int MAX_LISTS      = 8;
    localparam int LANE_W         = $clog2(MAX_LISTS);
    localparam int VALUE_BITS     = 32;
    localparam int LANE_DEPTH_DEF = 4;

    // configuration register
    localparam int CFG_W = 4;
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);

    // results per transaction
    localparam int RESULT_LIMIT = 32;
    localparam int KCNT_W       = $clog2(RESULT_LIMIT + 1);

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // one accepted input transaction for an active lane
    typedef struct packed {
        logic [LANE_W-1:0]     lane;
        logic [VALUE_BITS-1:0] value;
        logic                  has_elem;
        logic                  ends;
    } cmd_t;

    // lane bank control from the back part
    typedef struct packed {
        logic                  push;
        logic                  pop;
        logic                  set_end;
        logic                  clear;
        logic [LANE_W-1:0]     lane;
        logic [VALUE_BITS-1:0] value;
    } lane_ctrl_t;

    // lane bank status flags
    typedef struct packed {
        logic [MAX_LISTS-1:0] empty;
        logic [MAX_LISTS-1:0] ended;
        logic [MAX_LISTS-1:0] full;
    } lane_stat_t;

    // head candidate for the minimum search
    typedef struct packed {
        logic                  valid;
        logic [LANE_W-1:0]     lane;
        logic [VALUE_BITS-1:0] value;
    } cand_t;

    // one result without its run_last flag
    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic [LANE_W-1:0]     lane;
        logic                  done;
        logic                  empty;
        logic                  rej;
    } result_t;

    // back part sequencer
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_APPLY,
        BK_SETTLE,
        BK_DECIDE,
        BK_FINISH
    } back_state_t;

endpackage

/* rtl/core/kwm_queue.sv */
// ----------------------------------------------------------------------------
// kwm_queue: command queue between front and back
// Small circular FIFO of classified input transactions.
// ----------------------------------------------------------------------------
module kwm_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  kwm_pkg::cmd_t  push_data,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output kwm_pkg::cmd_t  pop_data
);

    kwm_pkg::cmd_t               mem_reg [kwm_pkg::QUEUE_DEPTH];
    logic [kwm_pkg::QPTR_W-1:0]  wr_ptr_reg;
    logic [kwm_pkg::QPTR_W-1:0]  wr_ptr_next;
    logic [kwm_pkg::QPTR_W-1:0]  rd_ptr_reg;
    logic [kwm_pkg::QPTR_W-1:0]  rd_ptr_next;
    logic [kwm_pkg::QCNT_W-1:0]  count_reg;
    logic [kwm_pkg::QCNT_W-1:0]  count_next;
    logic                        do_push;
    logic                        do_pop;

    // status
    assign full      = (count_reg == kwm_pkg::QCNT_W'(kwm_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // pointer and fill update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == kwm_pkg::QPTR_W'(kwm_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == kwm_pkg::QPTR_W'(kwm_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/core/kwm_front.sv */
// ----------------------------------------------------------------------------
// kwm_front: input side of the merge
// Accepts input transactions, drops those for inactive lanes and queues
// the rest as commands for the back part.
// ----------------------------------------------------------------------------
module kwm_front
(
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [kwm_pkg::LANE_W-1:0]       source_list,
    input  logic signed [kwm_pkg::VALUE_BITS-1:0] element,
    input  logic                             has_element,
    input  logic                             list_ends,
    input  logic [kwm_pkg::MAX_LISTS-1:0]    active,
    input  logic                             q_full,
    output logic                             q_push,
    output kwm_pkg::cmd_t                    q_data
);

    logic lane_active;

    // stall only while the queue has no room
    assign in_stall = q_full;

    // items for lanes outside the active set cause nothing
    assign lane_active = active[source_list];
    assign q_push      = in_valid && !q_full && lane_active;

    // command packing
    always_comb
    begin
        q_data.lane     = source_list;
        q_data.value    = element;
        q_data.has_elem = has_element;
        q_data.ends     = list_ends;
    end

endmodule

/* rtl/core/kwm_lanes.sv */
// ----------------------------------------------------------------------------
// kwm_lanes: lane bank and head minimum search
// One shifting FIFO per lane, status flags, and a registered pair stage
// of the head compare tree followed by the last two tree levels.
// ----------------------------------------------------------------------------
module kwm_lanes
#(
    parameter int LANE_DEPTH = kwm_pkg::LANE_DEPTH_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [kwm_pkg::MAX_LISTS-1:0]  active,
    input  kwm_pkg::lane_ctrl_t            ctrl,
    output kwm_pkg::lane_stat_t            stat,
    output kwm_pkg::cand_t                 best
);

    localparam int CNT_W = $clog2(LANE_DEPTH + 1);
    localparam int IDX_W = (LANE_DEPTH > 1) ? $clog2(LANE_DEPTH) : 1;
    localparam int PAIRS = kwm_pkg::MAX_LISTS / 2;

    logic [kwm_pkg::VALUE_BITS-1:0] store_reg [kwm_pkg::MAX_LISTS][LANE_DEPTH];
    logic [CNT_W-1:0]               count_reg [kwm_pkg::MAX_LISTS];
    logic [kwm_pkg::MAX_LISTS-1:0]  ended_reg;
    kwm_pkg::cand_t                 pair_reg  [PAIRS];
    kwm_pkg::cand_t                 pair_next [PAIRS];
    kwm_pkg::cand_t                 quad [2];

    // lower-index candidate wins ties
    function automatic kwm_pkg::cand_t cand_min(input kwm_pkg::cand_t a,
                                                input kwm_pkg::cand_t b);
        logic take_a;
        take_a = a.valid && (!b.valid || ($signed(a.value) <= $signed(b.value)));
        return take_a ? a : b;
    endfunction

    // status flags
    always_comb
    begin
        for (int i = 0; i < kwm_pkg::MAX_LISTS; i++)
        begin
            stat.empty[i] = (count_reg[i] == '0);
            stat.full[i]  = (count_reg[i] == CNT_W'(LANE_DEPTH));
            stat.ended[i] = ended_reg[i];
        end
    end

    // fill counts and end marks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < kwm_pkg::MAX_LISTS; i++)
            begin
                count_reg[i] <= '0;
            end
            ended_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            for (int i = 0; i < kwm_pkg::MAX_LISTS; i++)
            begin
                count_reg[i] <= '0;
            end
            ended_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < kwm_pkg::MAX_LISTS; i++)
            begin
                if (ctrl.lane == kwm_pkg::LANE_W'(i))
                begin
                    if (ctrl.push)
                    begin
                        count_reg[i] <= count_reg[i] + 1'b1;
                    end
                    else if (ctrl.pop)
                    begin
                        count_reg[i] <= count_reg[i] - 1'b1;
                    end
                    if (ctrl.set_end)
                    begin
                        ended_reg[i] <= 1'b1;
                    end
                end
            end
        end
    end

    // lane data: head always sits in entry 0, pop shifts down
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < kwm_pkg::MAX_LISTS; i++)
        begin
            if (ctrl.lane == kwm_pkg::LANE_W'(i))
            begin
                if (ctrl.pop)
                begin
                    for (int j = 0; j < LANE_DEPTH - 1; j++)
                    begin
                        store_reg[i][j] <= store_reg[i][j + 1];
                    end
                end
                else if (ctrl.push)
                begin
                    store_reg[i][count_reg[i][IDX_W-1:0]] <= ctrl.value;
                end
            end
        end
    end

    // first tree level over lane pairs
    always_comb
    begin
        kwm_pkg::cand_t ca;
        kwm_pkg::cand_t cb;
        for (int p = 0; p < PAIRS; p++)
        begin
            ca.valid = active[2*p] && (count_reg[2*p] != '0);
            ca.lane  = kwm_pkg::LANE_W'(2*p);
            ca.value = store_reg[2*p][0];
            cb.valid = active[2*p+1] && (count_reg[2*p+1] != '0);
            cb.lane  = kwm_pkg::LANE_W'(2*p+1);
            cb.value = store_reg[2*p+1][0];
            pair_next[p] = cand_min(ca, cb);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < PAIRS; p++)
            begin
                pair_reg[p] <= '0;
            end
        end
        else
        begin
            for (int p = 0; p < PAIRS; p++)
            begin
                pair_reg[p] <= pair_next[p];
            end
        end
    end

    // remaining two levels for the eight-lane bank
    assign quad[0] = cand_min(pair_reg[0], pair_reg[1]);
    assign quad[1] = cand_min(pair_reg[2], pair_reg[3]);
    assign best    = cand_min(quad[0], quad[1]);

endmodule

/* rtl/core/kwm_back.sv */
// ----------------------------------------------------------------------------
// kwm_back: merge sequencer and result output
// Applies queued commands to the lane bank, picks heads in order, holds
// one result back to mark the last of a run, and drives the output register.
// ----------------------------------------------------------------------------
module kwm_back
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_valid,
    input  kwm_pkg::cmd_t                  q_data,
    output logic                           q_pop,
    input  logic [kwm_pkg::MAX_LISTS-1:0]  active,
    input  kwm_pkg::lane_stat_t            stat,
    input  kwm_pkg::cand_t                 best,
    output kwm_pkg::lane_ctrl_t            ctrl,
    input  logic                           out_stall,
    output logic                           out_valid,
    output kwm_pkg::result_t               out_res,
    output logic                           out_last
);

    kwm_pkg::back_state_t         state_reg;
    kwm_pkg::back_state_t         state_next;
    kwm_pkg::cmd_t                cmd_reg;
    kwm_pkg::cmd_t                cmd_next;
    logic [kwm_pkg::KCNT_W-1:0]   k_reg;
    logic [kwm_pkg::KCNT_W-1:0]   k_next;
    logic                         pend_valid_reg;
    logic                         pend_valid_next;
    kwm_pkg::result_t             pend_reg;
    kwm_pkg::result_t             pend_next;
    logic                         any_emitted_reg;
    logic                         any_emitted_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    kwm_pkg::result_t             out_reg;
    kwm_pkg::result_t             out_next;
    logic                         out_last_reg;
    logic                         out_last_next;

    logic                         out_free;
    logic                         can_emit;
    logic                         all_done;
    logic                         blocked;
    logic                         under_limit;
    logic                         do_emit;
    kwm_pkg::result_t             new_res;

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;
    assign out_last  = out_last_reg;

    // merge conditions over the active lanes
    assign all_done    = &(~active | (stat.empty & stat.ended));
    assign blocked     = |(active & stat.empty & ~stat.ended);
    assign under_limit = (k_reg < kwm_pkg::KCNT_W'(kwm_pkg::RESULT_LIMIT));
    assign out_free    = !out_valid_reg || !out_stall;
    assign can_emit    = !pend_valid_reg || out_free;

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        k_next           = k_reg;
        pend_valid_next  = pend_valid_reg;
        pend_next        = pend_reg;
        any_emitted_next = any_emitted_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_next         = out_reg;
        out_last_next    = out_last_reg;
        q_pop            = 1'b0;
        do_emit          = 1'b0;
        new_res          = '0;
        ctrl             = '0;
        ctrl.lane        = cmd_reg.lane;
        ctrl.value       = cmd_reg.value;

        unique case (state_reg)
            kwm_pkg::BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_data;
                    k_next     = '0;
                    state_next = kwm_pkg::BK_APPLY;
                end
            end

            // element store or reject, then end mark
            kwm_pkg::BK_APPLY:
            begin
                if (cmd_reg.has_elem)
                begin
                    if (stat.ended[cmd_reg.lane] || stat.full[cmd_reg.lane])
                    begin
                        pend_next.value = cmd_reg.value;
                        pend_next.lane  = cmd_reg.lane;
                        pend_next.done  = 1'b0;
                        pend_next.empty = 1'b0;
                        pend_next.rej   = 1'b1;
                        pend_valid_next = 1'b1;
                        k_next          = kwm_pkg::KCNT_W'(1);
                    end
                    else
                    begin
                        ctrl.push = 1'b1;
                    end
                end
                ctrl.set_end = cmd_reg.ends;
                state_next   = kwm_pkg::BK_SETTLE;
            end

            // pair stage catches up with the lane bank
            kwm_pkg::BK_SETTLE:
            begin
                state_next = kwm_pkg::BK_DECIDE;
            end

            kwm_pkg::BK_DECIDE:
            begin
                priority if (all_done)
                begin
                    if (!under_limit)
                    begin
                        ctrl.clear       = 1'b1;
                        any_emitted_next = 1'b0;
                        state_next       = kwm_pkg::BK_FINISH;
                    end
                    else if (can_emit)
                    begin
                        do_emit          = 1'b1;
                        new_res.done     = 1'b1;
                        new_res.empty    = !any_emitted_reg;
                        ctrl.clear       = 1'b1;
                        any_emitted_next = 1'b0;
                        state_next       = kwm_pkg::BK_FINISH;
                    end
                end
                else if (blocked || !best.valid || !under_limit)
                begin
                    state_next = kwm_pkg::BK_FINISH;
                end
                else if (can_emit)
                begin
                    do_emit          = 1'b1;
                    new_res.value    = best.value;
                    new_res.lane     = best.lane;
                    ctrl.pop         = 1'b1;
                    ctrl.lane        = best.lane;
                    any_emitted_next = 1'b1;
                    state_next       = kwm_pkg::BK_SETTLE;
                end
            end

            // release the held result as last of the run
            kwm_pkg::BK_FINISH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = kwm_pkg::BK_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_next        = pend_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = kwm_pkg::BK_IDLE;
                end
            end

            default:
            begin
                state_next = kwm_pkg::BK_IDLE;
            end
        endcase

        // a new result pushes the held one out
        if (do_emit)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_next       = pend_reg;
                out_last_next  = 1'b0;
            end
            pend_next       = new_res;
            pend_valid_next = 1'b1;
            k_next          = k_reg + 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= kwm_pkg::BK_IDLE;
            k_reg           <= '0;
            pend_valid_reg  <= 1'b0;
            any_emitted_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            k_reg           <= k_next;
            pend_valid_reg  <= pend_valid_next;
            any_emitted_reg <= any_emitted_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

endmodule

/* rtl/core/k_way_sorted_merge_top.sv */
// In the back part a transaction passes queue pop, apply and a pair stage settle
// before its first decision; each merged element then takes a settle step for
// the registered pair stage of the head compare tree and a decision, and a
// finish step closes the transaction. Each result reaches the output when the
// next result is made or at the finish step; inputs queue 2 deep ahead of the back part.
// Reset: asynchronous active low; lanes empty, lists_in_use 8, output idle.
// ----------------------------------------------------------------------------
// k_way_sorted_merge_top: k-way sorted merge
// Merges up to eight ascending lanes into one ascending stream, with reject
// notices for full or ended lanes and a done marker per merge within the limit.
// ----------------------------------------------------------------------------
module k_way_sorted_merge_top
#(
    parameter int LANE_DEPTH = kwm_pkg::LANE_DEPTH_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration write channel
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [kwm_pkg::CFG_W-1:0]              lists_in_use,
    // input channel
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [kwm_pkg::LANE_W-1:0]             source_list,
    input  logic signed [kwm_pkg::VALUE_BITS-1:0]  element,
    input  logic                                   has_element,
    input  logic                                   list_ends,
    // output channel
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [kwm_pkg::VALUE_BITS-1:0]  merged_value,
    output logic [kwm_pkg::LANE_W-1:0]             from_list,
    output logic                                   run_last,
    output logic                                   merge_done,
    output logic                                   empty_merge,
    output logic                                   rejected
);

    logic [kwm_pkg::CFG_W-1:0]      lists_reg;
    logic [kwm_pkg::CFG_W-1:0]      n_act;
    logic [kwm_pkg::MAX_LISTS-1:0]  active;
    logic                           q_full;
    logic                           q_push;
    kwm_pkg::cmd_t                  q_in;
    logic                           q_valid;
    logic                           q_pop;
    kwm_pkg::cmd_t                  q_out;
    kwm_pkg::lane_ctrl_t            lane_ctrl;
    kwm_pkg::lane_stat_t            lane_stat;
    kwm_pkg::cand_t                 best;
    kwm_pkg::result_t               out_res;
    logic                           out_last;

    // configuration register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lists_reg <= kwm_pkg::CFG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            lists_reg <= lists_in_use;
        end
    end

    // active lane mask, count clamped to one..MAX_LISTS
    always_comb
    begin
        if (lists_reg == '0)
        begin
            n_act = kwm_pkg::CFG_W'(1);
        end
        else if (lists_reg > kwm_pkg::CFG_W'(kwm_pkg::MAX_LISTS))
        begin
            n_act = kwm_pkg::CFG_W'(kwm_pkg::MAX_LISTS);
        end
        else
        begin
            n_act = lists_reg;
        end
        for (int i = 0; i < kwm_pkg::MAX_LISTS; i++)
        begin
            active[i] = (kwm_pkg::CFG_W'(i) < n_act);
        end
    end

    kwm_front u_front
    (
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .source_list (source_list),
        .element     (element),
        .has_element (has_element),
        .list_ends   (list_ends),
        .active      (active),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_in)
    );

    kwm_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_out)
    );

    kwm_lanes #(
        .LANE_DEPTH (LANE_DEPTH)
    ) u_lanes
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .active (active),
        .ctrl   (lane_ctrl),
        .stat   (lane_stat),
        .best   (best)
    );

    kwm_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_out),
        .q_pop     (q_pop),
        .active    (active),
        .stat      (lane_stat),
        .best      (best),
        .ctrl      (lane_ctrl),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_res   (out_res),
        .out_last  (out_last)
    );

    // output fields
    assign merged_value = out_res.value;
    assign from_list    = out_res.lane;
    assign run_last     = out_last;
    assign merge_done   = out_res.done;
    assign empty_merge  = out_res.empty;
    assign rejected     = out_res.rej;

`ifndef NO_ASSERTIONS
    // never store into a full lane
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        lane_ctrl.push |-> !lane_stat.full[lane_ctrl.lane])
        else $error("push into full lane");

    // only pop an active lane that holds data
    a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
        lane_ctrl.pop |-> (!lane_stat.empty[lane_ctrl.lane] && active[lane_ctrl.lane]))
        else $error("pop from empty or inactive lane");

    // done marker closes its run and is no reject
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && merge_done) |-> (run_last && !rejected))
        else $error("done marker not last of run");

    // empty flag only on a done marker
    a_empty_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && empty_merge) |-> merge_done)
        else $error("empty_merge without merge_done");
`endif

endmodule
